// File: rtl/core/arpm_pkg.sv
// Shared types and constants for the AT response prompt matcher.
`default_nettype none

package arpm_pkg;

  // Fixed field widths
  localparam int unsigned KindW     = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 5;
  localparam int unsigned CapW      = 8;
  localparam int unsigned TickW     = 32;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PatBytes  = 16;
  localparam int unsigned PatIdxW   = 4;
  localparam int unsigned PatW      = PatBytes * ByteW;

  // Carriage return ends response gathering
  localparam logic [ByteW-1:0] CrByte = 8'h0D;

  // Request kinds
  typedef enum logic [KindW-1:0] {
    KindStart = 2'd0,
    KindByte  = 2'd1,
    KindTick  = 2'd2
  } kind_e;

  // Wait phase, reported as status
  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhWait    = 2'd1,
    PhMatch   = 2'd2,
    PhTimeout = 2'd3
  } phase_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPromptLow  = 3'd0,
    CfgPromptHigh = 3'd1,
    CfgPromptLen  = 3'd2,
    CfgTermLow    = 3'd3,
    CfgTermHigh   = 3'd4,
    CfgTermLen    = 3'd5,
    CfgRespCap    = 3'd6,
    CfgTimeout    = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/core/arpm_if.sv
// Valid/ready channel interfaces for the matcher's requests and results.
`default_nettype none

interface arpm_in_if;
  import arpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface arpm_out_if;
  import arpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             resp_valid;
  logic [ByteW-1:0] resp_byte;
  logic [CapW-1:0]  resp_index;

  modport source (output valid, status, resp_valid, resp_byte, resp_index, input ready);
  modport sink   (input valid, status, resp_valid, resp_byte, resp_index, output ready);
endinterface

`default_nettype wire

// File: rtl/core/arpm_match_step.sv
// One step of pattern matching with the simple restart rule.
`default_nettype none

module arpm_match_step #(
  parameter int unsigned PosW = 5
) (
  input  logic [arpm_pkg::PatW-1:0]  pattern_i,
  input  logic [PosW-1:0]            pos_i,
  input  logic [arpm_pkg::ByteW-1:0] byte_i,
  output logic [PosW-1:0]            pos_o
);
  import arpm_pkg::*;

  logic [PatIdxW-1:0] idx;
  logic [ByteW-1:0]   expect_byte;
  logic [ByteW-1:0]   first_byte;

  // Pick the pattern byte at the current position
  assign idx         = PatIdxW'(pos_i);
  assign expect_byte = pattern_i[ByteW*idx +: ByteW];
  assign first_byte  = pattern_i[ByteW-1:0];

  // Advance on a hit, else restart at one or zero
  always_comb begin
    if (byte_i == expect_byte) begin
      pos_o = pos_i + PosW'(1);
    end else if (byte_i == first_byte) begin
      pos_o = PosW'(1);
    end else begin
      pos_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/at_response_prompt_matcher.sv
// Top level of the AT response prompt matcher.
`default_nettype none

// Takes one request (start, received byte or timer tick) per clock and gives
// exactly one result per request. A request's result appears in the output
// register on the cycle after it is accepted; a new request is taken every
// cycle as long as the output register is empty or being read, so the sustained
// rate is one request per cycle. That rate is set by the combinational update
// of the prompt and terminator match positions, the gathered count and the
// tick counter. There is no clearing pass after reset. Configuration registers
// are written through cfg_we_i/cfg_idx_i/cfg_data_i and should change only
// while no request is in flight.
module at_response_prompt_matcher #(
  parameter int unsigned MaxPattern = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [arpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [arpm_pkg::CfgDataW-1:0] cfg_data_i,
  arpm_in_if.sink                     in_i,
  arpm_out_if.source                  out_o
);
  import arpm_pkg::*;

  localparam int unsigned PosW = $clog2(MaxPattern + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPattern);

  // Configuration registers
  logic [PatW-1:0]  prompt_q;
  logic [LenW-1:0]  prompt_len_q;
  logic [PatW-1:0]  term_q;
  logic [LenW-1:0]  term_len_q;
  logic [CapW-1:0]  resp_cap_q;
  logic [TickW-1:0] timeout_q;

  // Wait state
  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  ppos_q, ppos_d;
  logic [PosW-1:0]  tpos_q, tpos_d;
  logic [CapW-1:0]  gcnt_q, gcnt_d;
  logic [TickW-1:0] elapsed_q, elapsed_d;
  logic             gdone_q, gdone_d;

  // Output register
  logic             out_valid_q;
  phase_e           status_q;
  logic             resp_valid_q, resp_valid_d;
  logic [ByteW-1:0] resp_byte_q, resp_byte_d;
  logic [CapW-1:0]  resp_index_q, resp_index_d;

  logic             in_fire;
  logic [PosW-1:0]  plen;
  logic [PosW-1:0]  tlen;
  logic [PosW-1:0]  tpos_cur;
  logic [PosW-1:0]  ppos_next;
  logic [PosW-1:0]  tpos_next;
  logic [TickW-1:0] elapsed_inc;
  logic [CapW:0]    gcnt_plus2;
  logic [ByteW-1:0] c;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign c        = in_i.rx_byte;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_q     <= '0;
      prompt_len_q <= '0;
      term_q       <= '0;
      term_len_q   <= LenW'(1);
      resp_cap_q   <= '0;
      timeout_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPromptLow:  prompt_q[CfgDataW-1:0]      <= cfg_data_i;
        CfgPromptHigh: prompt_q[PatW-1:CfgDataW]   <= cfg_data_i;
        CfgPromptLen:  prompt_len_q                <= cfg_data_i[LenW-1:0];
        CfgTermLow:    term_q[CfgDataW-1:0]        <= cfg_data_i;
        CfgTermHigh:   term_q[PatW-1:CfgDataW]     <= cfg_data_i;
        CfgTermLen:    term_len_q                  <= cfg_data_i[LenW-1:0];
        CfgRespCap:    resp_cap_q                  <= cfg_data_i[CapW-1:0];
        CfgTimeout:    timeout_q                   <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp pattern lengths; a zero terminator length counts as one
  always_comb begin
    plen = (prompt_len_q > MaxLen) ? PosW'(MaxLen) : PosW'(prompt_len_q);
    if (term_len_q > MaxLen) begin
      tlen = PosW'(MaxLen);
    end else if (term_len_q == '0) begin
      tlen = PosW'(1);
    end else begin
      tlen = PosW'(term_len_q);
    end
  end

  // Wrap the terminator position once a full match was seen
  assign tpos_cur = (tpos_q >= tlen) ? '0 : tpos_q;

  arpm_match_step #(.PosW(PosW)) u_prompt_step (
    .pattern_i (prompt_q),
    .pos_i     (ppos_q),
    .byte_i    (c),
    .pos_o     (ppos_next)
  );

  arpm_match_step #(.PosW(PosW)) u_term_step (
    .pattern_i (term_q),
    .pos_i     (tpos_cur),
    .byte_i    (c),
    .pos_o     (tpos_next)
  );

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TickW'(1);
  assign gcnt_plus2  = {1'b0, gcnt_q} + (CapW+1)'(2);

  // Compute the next wait state and result
  always_comb begin
    phase_d      = phase_q;
    ppos_d       = ppos_q;
    tpos_d       = tpos_q;
    gcnt_d       = gcnt_q;
    elapsed_d    = elapsed_q;
    gdone_d      = gdone_q;
    resp_valid_d = 1'b0;
    resp_byte_d  = '0;
    resp_index_d = '0;
    case (kind_e'(in_i.kind))
      KindStart: begin
        ppos_d    = '0;
        tpos_d    = '0;
        gcnt_d    = '0;
        elapsed_d = '0;
        gdone_d   = 1'b0;
        phase_d   = (timeout_q == '0) ? PhTimeout : PhWait;
      end
      KindTick: begin
        if (phase_q == PhWait) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            phase_d = PhTimeout;
          end
        end
      end
      KindByte: begin
        if (phase_q == PhWait) begin
          if (elapsed_q >= timeout_q) begin
            phase_d = PhTimeout;
          end else begin
            // Prompt match, then gather the response
            if (plen != '0) begin
              if (ppos_q < plen) begin
                ppos_d = ppos_next;
              end else if (!gdone_q && resp_cap_q != '0) begin
                if (c == CrByte || gcnt_plus2 > {1'b0, resp_cap_q}) begin
                  gdone_d = 1'b1;
                end else begin
                  resp_valid_d = 1'b1;
                  resp_byte_d  = c;
                  resp_index_d = gcnt_q;
                  gcnt_d       = gcnt_q + CapW'(1);
                end
              end
            end
            // Terminator match
            tpos_d = tpos_next;
            if (tpos_next >= tlen) begin
              phase_d = PhMatch;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Hold wait state; advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      ppos_q    <= '0;
      tpos_q    <= '0;
      gcnt_q    <= '0;
      elapsed_q <= '0;
      gdone_q   <= 1'b0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      ppos_q    <= ppos_d;
      tpos_q    <= tpos_d;
      gcnt_q    <= gcnt_d;
      elapsed_q <= elapsed_d;
      gdone_q   <= gdone_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q     <= phase_d;
      resp_valid_q <= resp_valid_d;
      resp_byte_q  <= resp_byte_d;
      resp_index_q <= resp_index_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.resp_valid = resp_valid_q;
  assign out_o.resp_byte  = resp_byte_q;
  assign out_o.resp_index = resp_index_q;

  // Tick count only grows within a wait
  a_elapsed_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.kind != KindStart |=> elapsed_q >= $past(elapsed_q))
    else $error("elapsed tick count went down without a start");

  // Gathered count moves exactly when a response byte goes out
  a_gather_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.kind != KindStart |=> (gcnt_q != $past(gcnt_q)) == resp_valid_q)
    else $error("gathered count out of step with response bytes");

  // Only a start leaves a finished or idle phase
  a_phase_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q != PhWait && in_i.kind != KindStart |=> phase_q == $past(phase_q))
    else $error("phase changed outside a wait without a start");

  // A response byte is reported only after the prompt matched
  a_resp_after_prompt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && resp_valid_d |-> ppos_q >= plen && plen != '0)
    else $error("response byte gathered before the prompt matched");

endmodule

`default_nettype wire

// File: bench/at_response_prompt_matcher_test.sv
// Self-checking bench for the AT response prompt matcher: directed and random requests.
module at_response_prompt_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import arpm_pkg::*;

  // Request kind the block does not define; it must change nothing
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned MaxPatLen = 16;
  localparam int unsigned TargetItems = 1500;

  // Symbols that make up most patterns and stimulus bytes
  localparam logic [ByteW-1:0] SymPlus  = 8'h2B;
  localparam logic [ByteW-1:0] SymColon = 8'h3A;
  localparam logic [ByteW-1:0] SymO     = 8'h4F;
  localparam logic [ByteW-1:0] SymK     = 8'h4B;

  typedef struct packed {
    phase_e           status;
    logic             resp_valid;
    logic [ByteW-1:0] resp_byte;
    logic [CapW-1:0]  resp_index;
  } response_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  arpm_in_if  request_ch ();
  arpm_out_if result_ch ();

  at_response_prompt_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (request_ch),
    .out_o      (result_ch)
  );

  // Register copies as the block should hold them
  logic [PatW-1:0]  prompt_pat;
  logic [PatW-1:0]  term_pat;
  logic [LenW-1:0]  prompt_len_q;
  logic [LenW-1:0]  term_len_q;
  logic [CapW-1:0]  resp_cap_q;
  logic [TickW-1:0] timeout_q;

  // Wait state as the block should hold it
  phase_e           wait_phase;
  int unsigned      prompt_pos;
  int unsigned      term_pos;
  logic [CapW-1:0]  gathered;
  logic [TickW-1:0] elapsed;
  bit               gather_done;

  response_t   awaited_responses[$];
  int unsigned error_count;
  int unsigned items_sent;
  bit          src_idle;
  bit          snk_idle;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [ByteW-1:0] pattern_byte(input logic [PatW-1:0] pat,
                                                    input int unsigned idx);
    return pat[8*(idx % MaxPatLen) +: 8];
  endfunction

  function automatic int unsigned prompt_span();
    return (prompt_len_q > MaxPatLen) ? MaxPatLen : int'(prompt_len_q);
  endfunction

  function automatic int unsigned term_span();
    int unsigned n;
    n = (term_len_q > MaxPatLen) ? MaxPatLen : int'(term_len_q);
    return (n == 0) ? 1 : n;
  endfunction

  // Advance the wait state by one request and return the result it gives
  function automatic response_t predict_response(input logic [KindW-1:0] kind,
                                                 input logic [ByteW-1:0] rx);
    response_t   res;
    int unsigned plen;
    int unsigned tlen;
    res = '0;
    case (kind)
      KindStart: begin
        prompt_pos  = 0;
        term_pos    = 0;
        gathered    = '0;
        elapsed     = '0;
        gather_done = 1'b0;
        wait_phase  = (timeout_q == '0) ? PhTimeout : PhWait;
      end
      KindTick: begin
        if (wait_phase == PhWait) begin
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (elapsed >= timeout_q) wait_phase = PhTimeout;
        end
      end
      KindByte: begin
        if (wait_phase == PhWait) begin
          if (elapsed >= timeout_q) begin
            wait_phase = PhTimeout;
          end else begin
            plen = prompt_span();
            tlen = term_span();
            // Prompt match first, then gather what follows it
            if (plen != 0) begin
              if (prompt_pos < plen) begin
                if (rx == pattern_byte(prompt_pat, prompt_pos)) prompt_pos++;
                else prompt_pos = (rx == pattern_byte(prompt_pat, 0)) ? 1 : 0;
              end else if (!gather_done && resp_cap_q != '0) begin
                if (rx == CrByte || int'(gathered) + 2 > int'(resp_cap_q)) begin
                  gather_done = 1'b1;
                end else begin
                  res.resp_valid = 1'b1;
                  res.resp_byte  = rx;
                  res.resp_index = gathered;
                  gathered       = gathered + 1'b1;
                end
              end
            end
            // Terminator tracking on every byte
            if (term_pos >= tlen) term_pos = 0;
            if (rx == pattern_byte(term_pat, term_pos)) term_pos++;
            else term_pos = (rx == pattern_byte(term_pat, 0)) ? 1 : 0;
            if (term_pos >= tlen) wait_phase = PhMatch;
          end
        end
      end
      default: ;
    endcase
    res.status = wait_phase;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    error_count++;
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_response();
    response_t got;
    response_t want;
    got.status     = phase_e'(result_ch.status);
    got.resp_valid = result_ch.resp_valid;
    got.resp_byte  = result_ch.resp_byte;
    got.resp_index = result_ch.resp_index;
    if (awaited_responses.size() == 0) begin
      report_mismatch("unexpected result status", got.status, 0);
      return;
    end
    want = awaited_responses.pop_front();
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.resp_valid !== want.resp_valid)
      report_mismatch("resp_valid", got.resp_valid, want.resp_valid);
    if (got.resp_byte !== want.resp_byte)
      report_mismatch("resp_byte", got.resp_byte, want.resp_byte);
    if (got.resp_index !== want.resp_index)
      report_mismatch("resp_index", got.resp_index, want.resp_index);
  endtask

  // Send one request, then record its expected result once it is taken
  task automatic send_request(input logic [KindW-1:0] kind, input logic [ByteW-1:0] rx);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    request_ch.valid   <= 1'b1;
    request_ch.kind    <= kind;
    request_ch.rx_byte <= rx;
    do @(posedge clk_i); while (request_ch.ready !== 1'b1);
    items_sent++;
    awaited_responses.push_back(predict_response(kind, rx));
  endtask

  task automatic send_byte(input logic [ByteW-1:0] rx);
    send_request(KindByte, rx);
  endtask

  task automatic send_tick();
    send_request(KindTick, ByteW'($urandom_range(0, 255)));
  endtask

  // Hold requests until every expected result has come back
  task automatic hold_until_drained();
    request_ch.valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgPromptLow:  prompt_pat[63:0]   = value;
      CfgPromptHigh: prompt_pat[127:64] = value;
      CfgPromptLen:  prompt_len_q       = value[LenW-1:0];
      CfgTermLow:    term_pat[63:0]     = value;
      CfgTermHigh:   term_pat[127:64]   = value;
      CfgTermLen:    term_len_q         = value[LenW-1:0];
      CfgRespCap:    resp_cap_q         = value[CapW-1:0];
      CfgTimeout:    timeout_q          = value[TickW-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [ByteW-1:0] pick_symbol();
    case ($urandom_range(0, 7))
      0:       return SymPlus;
      1:       return SymColon;
      2:       return SymO;
      3:       return SymK;
      4:       return CrByte;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PatW-1:0] random_pattern();
    logic [PatW-1:0] pat;
    case ($urandom_range(0, 9))
      0:       pat = '0;
      1:       pat = '1;
      default: for (int i = 0; i < MaxPatLen; i++) pat[8*i +: 8] = pick_symbol();
    endcase
    return pat;
  endfunction

  // Noise that is not a start: stray bytes, ticks and the undefined kind
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0, 1:    send_byte(ByteW'($urandom_range(0, 255)));
      2:       send_byte(pick_symbol());
      3, 4:    send_tick();
      default: send_request(KindUnused, ByteW'($urandom_range(0, 255)));
    endcase
  endtask

  // Idle state after reset: nothing but a start does anything
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_request(KindUnused, 8'hFF);
    send_tick();
    send_request(KindStart, 8'h00);  // zero timeout ends the wait at once
    send_byte(8'hFF);
  endtask

  // Prompt restart, gathering and capacity stop, then terminator match
  task automatic test_prompt_gather();
    hold_until_drained();
    write_register(CfgPromptLow, {48'h0, SymColon, SymPlus});
    write_register(CfgPromptHigh, '0);
    write_register(CfgPromptLen, 64'd2);
    write_register(CfgTermLow, {48'h0, SymK, SymO});
    write_register(CfgTermHigh, '0);
    write_register(CfgTermLen, 64'd2);
    write_register(CfgRespCap, 64'd3);
    write_register(CfgTimeout, 64'd50);
    send_request(KindStart, 8'h00);
    send_byte(SymPlus);
    send_byte(SymPlus);
    send_byte(SymColon);
    send_byte("a");
    send_byte("b");
    send_byte("c");
    send_byte(SymO);
    send_byte(SymK);
  endtask

  // Carriage return stops gathering; ticks run out the wait
  task automatic test_cr_and_timeout();
    hold_until_drained();
    write_register(CfgTermLow, '1);
    write_register(CfgTermHigh, '1);
    write_register(CfgTermLen, 64'd31);
    write_register(CfgRespCap, 64'd255);
    write_register(CfgTimeout, 64'd2);
    send_request(KindStart, 8'hFF);
    send_byte(SymPlus);
    send_byte(SymColon);
    send_byte(8'hFF);
    send_byte(CrByte);
    send_byte("x");
    send_tick();
    send_tick();
    send_byte(8'h00);
  endtask

  // Zero capacity, zero terminator length, and a timeout lowered mid-wait
  task automatic test_lowered_timeout();
    hold_until_drained();
    write_register(CfgPromptLow, {56'h0, SymPlus});
    write_register(CfgPromptLen, 64'd1);
    write_register(CfgTermLow, '0);
    write_register(CfgTermLen, 64'd0);
    write_register(CfgRespCap, 64'd0);
    write_register(CfgTimeout, 64'd50);
    send_request(KindStart, 8'h00);
    send_byte(SymPlus);
    send_byte("z");
    send_tick();
    hold_until_drained();
    write_register(CfgTimeout, 64'd1);
    send_byte(8'h00);  // dropped: elapsed ticks already reach the new limit
    send_request(KindStart, 8'h00);
    send_byte(8'h00);
  endtask

  // Fill the largest response buffer, then run past its end
  task automatic test_full_capacity();
    logic [ByteW-1:0] b;
    hold_until_drained();
    write_register(CfgTermLow, 64'h4B4F_0A0D_4B4F_0A0D);
    write_register(CfgTermHigh, 64'h4B4F_0A0D_4B4F_0A0D);
    write_register(CfgTermLen, 64'd16);
    write_register(CfgRespCap, 64'd255);
    write_register(CfgTimeout, '1);
    send_request(KindStart, 8'h00);
    send_byte(SymPlus);
    for (int i = 0; i < 258; i++) begin
      b = ByteW'($urandom_range(0, 255));
      if (b == CrByte) b = 8'h0E;
      send_byte(b);
      if ($urandom_range(0, 15) == 0) send_tick();
    end
    for (int i = 0; i < MaxPatLen; i++) send_byte(pattern_byte(term_pat, i));
  endtask

  task automatic randomize_registers();
    logic [CfgDataW-1:0] junk;
    logic [PatW-1:0]     pat;
    junk = {$urandom, $urandom};
    pat = random_pattern();
    write_register(CfgPromptLow, pat[CfgDataW-1:0]);
    write_register(CfgPromptHigh, pat[PatW-1:CfgDataW]);
    case ($urandom_range(0, 5))
      0:       junk[LenW-1:0] = 5'd0;
      1, 2:    junk[LenW-1:0] = LenW'($urandom_range(1, 4));
      3:       junk[LenW-1:0] = 5'd16;
      4:       junk[LenW-1:0] = LenW'($urandom_range(17, 31));
      default: junk[LenW-1:0] = LenW'($urandom_range(5, 15));
    endcase
    write_register(CfgPromptLen, junk);
    pat = random_pattern();
    write_register(CfgTermLow, pat[CfgDataW-1:0]);
    write_register(CfgTermHigh, pat[PatW-1:CfgDataW]);
    junk = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       junk[LenW-1:0] = 5'd0;
      1, 2:    junk[LenW-1:0] = LenW'($urandom_range(1, 4));
      3:       junk[LenW-1:0] = 5'd16;
      4:       junk[LenW-1:0] = LenW'($urandom_range(17, 31));
      default: junk[LenW-1:0] = LenW'($urandom_range(5, 8));
    endcase
    write_register(CfgTermLen, junk);
    junk = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0:       junk[CapW-1:0] = 8'd0;
      1:       junk[CapW-1:0] = 8'd1;
      2:       junk[CapW-1:0] = 8'd2;
      3:       junk[CapW-1:0] = 8'd255;
      4:       junk[CapW-1:0] = CapW'($urandom_range(0, 255));
      default: junk[CapW-1:0] = CapW'($urandom_range(3, 20));
    endcase
    write_register(CfgRespCap, junk);
    junk = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       junk[TickW-1:0] = '0;
      1, 2:    junk[TickW-1:0] = TickW'($urandom_range(1, 3));
      3:       junk[TickW-1:0] = '1;
      4:       junk[TickW-1:0] = $urandom;
      default: junk[TickW-1:0] = TickW'($urandom_range(10, 60));
    endcase
    write_register(CfgTimeout, junk);
  endtask

  // One wait: start, prompt, response bytes, terminator, with some damage
  task automatic run_wait_sequence();
    int unsigned n;
    logic [ByteW-1:0] b;
    send_request(KindStart, ByteW'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) send_noise();
    if ($urandom_range(0, 4) != 0) begin
      for (int unsigned i = 0; i < prompt_span(); i++) begin
        b = pattern_byte(prompt_pat, i);
        if ($urandom_range(0, 19) == 0) b = pick_symbol();
        send_byte(b);
        if ($urandom_range(0, 14) == 0) send_tick();
      end
    end
    n = $urandom_range(0, 10);
    if (resp_cap_q <= 20 && $urandom_range(0, 2) == 0) n = resp_cap_q + 2;
    repeat (n) begin
      b = ByteW'($urandom_range(0, 255));
      if ($urandom_range(0, 11) == 0) b = CrByte;
      send_byte(b);
      if ($urandom_range(0, 9) == 0) send_tick();
    end
    for (int unsigned i = 0; i < term_span(); i++) begin
      b = pattern_byte(term_pat, i);
      if ($urandom_range(0, 14) == 0) b = pick_symbol();
      send_byte(b);
    end
    repeat ($urandom_range(0, 2)) send_noise();
  endtask

  // Random phases: new settings and idle pattern, then mostly well-formed waits
  task automatic test_random_traffic();
    int unsigned phase_end;
    while (items_sent < TargetItems) begin
      hold_until_drained();
      randomize_registers();
      case ($urandom_range(0, 3))
        0:       begin src_idle = 1'b1; snk_idle = 1'b1; end
        1:       begin src_idle = 1'b0; snk_idle = 1'b1; end
        2:       begin src_idle = 1'b1; snk_idle = 1'b0; end
        default: begin src_idle = 1'b0; snk_idle = 1'b0; end
      endcase
      phase_end = items_sent + $urandom_range(60, 140);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(5, 15)) send_noise();
        else run_wait_sequence();
        if ($urandom_range(0, 24) == 0) hold_until_drained();
      end
    end
  endtask

  // Take results with random stalls and check each one
  initial begin : result_sink
    int unsigned stall;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_idle ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (result_ch.valid !== 1'b1);
      check_response();
    end
  end

  initial begin : stimulus
    request_ch.valid   <= 1'b0;
    request_ch.kind    <= KindStart;
    request_ch.rx_byte <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgPromptLow;
    cfg_data_i         <= '0;
    rst_ni             <= 1'b0;
    prompt_pat   = '0;
    term_pat     = '0;
    prompt_len_q = '0;
    term_len_q   = 5'd1;
    resp_cap_q   = '0;
    timeout_q    = '0;
    wait_phase   = PhIdle;
    prompt_pos   = 0;
    term_pos     = 0;
    gathered     = '0;
    elapsed      = '0;
    gather_done  = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    src_idle     = 1'b1;
    snk_idle     = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_prompt_gather();
    test_cr_and_timeout();
    test_lowered_timeout();
    test_full_capacity();
    test_random_traffic();

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("at_response_prompt_matcher verification clean");
    end else begin
      $display("at_response_prompt_matcher verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #2_000_000;
    $display("at_response_prompt_matcher verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/arpm_pkg.sv
rtl/core/arpm_if.sv
rtl/core/arpm_match_step.sv
rtl/core/at_response_prompt_matcher.sv
bench/at_response_prompt_matcher_test.sv
